// ===== design/tllr_pkg.sv =====
// Shared constants, types and font helpers for the typed letter LED renderer.
package tllr_pkg;

	localparam int GLYPH_TOTAL = 37;
	localparam int FONT_HEIGHT = 5;

	localparam logic [15:0] HOLD_MS      = 16'd900;
	localparam logic [15:0] FADE_END_MS  = 16'd1600;
	localparam logic [9:0]  FADE_SPAN_MS = 10'd700;
	localparam logic [8:0]  PERIOD_BASE  = 9'd300;
	localparam logic [8:0]  PERIOD_MIN   = 9'd40;
	localparam logic [7:0]  HUE_LETTER   = 8'd28;
	localparam logic [7:0]  HUE_GLYPH    = 8'd10;
	localparam logic [7:0]  FADE_FULL    = 8'hFF;

	localparam logic [1:0] CFG_EFFECT     = 2'd0;
	localparam logic [1:0] CFG_SPEED      = 2'd1;
	localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;

	localparam logic [0:0] EFFECT_MARQUEE = 1'b0;
	localparam logic [0:0] EFFECT_BIG     = 1'b1;

	localparam logic [0:0] MODE_KEY   = 1'b0;
	localparam logic [0:0] MODE_QUERY = 1'b1;

	// one octal digit per font row, top row first; bit 2 of a digit is the left column
	localparam logic [14:0] FONT [GLYPH_TOTAL] = '{
		15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74647, 15'o74644,
		15'o34553, 15'o55755, 15'o72227, 15'o11152, 15'o56465, 15'o44447,
		15'o57755, 15'o57775, 15'o25552, 15'o65644, 15'o25563, 15'o65655,
		15'o34216, 15'o72222, 15'o55557, 15'o55552, 15'o55775, 15'o55255,
		15'o55222, 15'o71247,
		15'o75557, 15'o26227, 15'o61247, 15'o71317, 15'o55711, 15'o74717,
		15'o34757, 15'o71244, 15'o75757, 15'o75716,
		15'o00000
	};

	typedef struct packed {
		logic       valid;
		logic [5:0] glyph;
	} glyph_map_t;

	function automatic glyph_map_t code_to_glyph(input logic [15:0] code);
		glyph_map_t r;
		r.valid = 1'b1;
		r.glyph = 6'd0;
		if (code >= 16'd4 && code <= 16'd29) begin
			r.glyph = 6'(code - 16'd4);
		end else if (code >= 16'd30 && code <= 16'd38) begin
			r.glyph = 6'(code - 16'd3);
		end else if (code == 16'd39) begin
			r.glyph = 6'd26;
		end else if (code == 16'd44) begin
			r.glyph = 6'd36;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

	function automatic logic font_pixel(input logic [5:0] glyph, input logic [1:0] fcol,
			input logic [2:0] row);
		logic [14:0] bits;
		logic [2:0]  rb;
		logic        px;
		px = 1'b0;
		if (glyph < 6'(GLYPH_TOTAL) && fcol != 2'd3 && row < 3'(FONT_HEIGHT)) begin
			bits = FONT[glyph];
			rb = 3'(bits >> (4'd3 * (4'd4 - {1'b0, row})));
			case (fcol)
				2'd0:    px = rb[2];
				2'd1:    px = rb[1];
				default: px = rb[0];
			endcase
		end
		return px;
	endfunction

endpackage

// ===== design/typed_letter_led_renderer_unit.sv =====
// Top level of the typed letter LED renderer: key ring, serial divider and pixel output.
//
// Key events (tuser = 0) are taken directly in ST_IDLE and give no output
// transfer; a key event can follow in the very next cycle. A render query
// (tuser = 1) passes from its input transfer through ST_DIV, the bit-serial
// divider, which yields one quotient bit per cycle and folds it into the scroll
// position modulo the marquee span at the same time (in big mode it divides the
// fade ramp times 255 by 700), then ST_ADDR for address decode and ring read
// and ST_OUT for font lookup and value scaling and the load of the output
// register. The next item is taken once the query has been loaded into the
// output register, even while that result still waits for its transfer. No
// clearing pass runs after reset; ring slots are used only once written.
module typed_letter_led_renderer_unit #(
	parameter int RING_DEPTH   = 16,
	parameter int GRID_COLUMNS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// key_code[15:0], key_pressed[16], grid_column[20:17], grid_row[23:21], time_ms[55:24]
	input  logic [55:0] s_axis_tdata,
	// mode[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_lit[0], pixel_hue[8:1], pixel_value[16:9], zero[23:17]
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tllr_pkg::*;

	localparam int HW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW     = $clog2(RING_DEPTH + 1);
	localparam int SW     = CW + 1;
	localparam int SPAN_W = $clog2(4 * RING_DEPTH + GRID_COLUMNS + 1);
	localparam int PW     = SPAN_W + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_ADDR, ST_OUT} state_t;
	typedef enum logic [1:0] {FS_HOLD, FS_FADE, FS_OFF} fade_sel_t;

	state_t      state_q;
	fade_sel_t   fade_sel_q;
	logic [0:0]  effect_q;
	logic [7:0]  speed_q;
	logic [7:0]  bright_q;
	logic [HW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [15:0] npt_q;

	logic [5:0]  ring [RING_DEPTH];
	logic [5:0]  rd_q;
	logic        ring_we;
	logic [HW-1:0] rd_addr;

	logic [31:0] dvd_q;
	logic [9:0]  dvs_q;
	logic [9:0]  rem_q;
	logic [SPAN_W-1:0] span_q;
	logic [SPAN_W-1:0] mod_q;
	logic [7:0]  q8_q;
	logic [4:0]  cnt_q;

	logic [3:0]  col_q;
	logic [2:0]  row_q;
	logic        ok_q;
	logic [1:0]  fcol_q;
	logic [CW-1:0] letter_q;
	logic [7:0]  fade_q;

	logic        out_valid_q;
	logic        out_lit_q;
	logic [7:0]  out_hue_q;
	logic [7:0]  out_val_q;

	// input unpack
	logic [15:0] in_code;
	logic        in_pressed;
	logic [3:0]  in_col;
	logic [2:0]  in_row;
	logic [31:0] in_time;
	assign in_code    = s_axis_tdata[15:0];
	assign in_pressed = s_axis_tdata[16];
	assign in_col     = s_axis_tdata[20:17];
	assign in_row     = s_axis_tdata[23:21];
	assign in_time    = s_axis_tdata[55:24];

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	glyph_map_t key_map;
	assign key_map = code_to_glyph(in_code);
	assign ring_we = accept && (s_axis_tuser == MODE_KEY) && in_pressed && key_map.valid;

	// query setup
	logic [8:0]  period;
	logic [15:0] elapsed;
	logic [9:0]  ramp;
	logic [17:0] ramp_x255;
	always_comb begin
		period = PERIOD_BASE - {1'b0, speed_q};
		if (period < PERIOD_MIN) begin
			period = PERIOD_MIN;
		end
		elapsed = in_time[15:0] - npt_q;
		ramp = 10'(elapsed - HOLD_MS);
		ramp_x255 = {ramp, 8'b0} - 18'(ramp);
	end

	// divider step
	logic [10:0] part;
	logic        qbit;
	logic [SPAN_W:0] mod2;
	always_comb begin
		part = {rem_q, dvd_q[31]};
		qbit = (part >= {1'b0, dvs_q});
		mod2 = {mod_q, qbit};
	end

	// address decode
	logic [PW-1:0] pos;
	logic [PW-1:0] tpos;
	logic [CW-1:0] letter;
	logic [SW-1:0] slot_sum;
	logic [HW-1:0] slot_m;
	logic [HW-1:0] slot_b;
	logic          in_text;
	logic          row_ok;
	logic [7:0]    fade;
	logic [3:0]    bcol;
	always_comb begin
		pos = PW'(col_q) + PW'(mod_q);
		tpos = pos - PW'(GRID_COLUMNS);
		in_text = (pos >= PW'(GRID_COLUMNS)) && (tpos < PW'({count_q, 2'b00}));
		letter = CW'(tpos >> 2);
		slot_sum = SW'(head_q) + SW'(RING_DEPTH) - SW'(count_q) + SW'(letter);
		if (slot_sum >= SW'(RING_DEPTH)) begin
			slot_sum = slot_sum - SW'(RING_DEPTH);
		end
		slot_m = HW'(slot_sum);
		slot_b = (head_q == '0) ? HW'(RING_DEPTH - 1) : HW'(head_q - 1'b1);
		row_ok = (row_q < 3'(FONT_HEIGHT)) && (count_q != '0);
		bcol = col_q - 4'd5;
		case (fade_sel_q)
			FS_HOLD: fade = FADE_FULL;
			FS_FADE: fade = FADE_FULL - q8_q;
			default: fade = 8'd0;
		endcase
		rd_addr = (effect_q == EFFECT_MARQUEE) ? slot_m : slot_b;
	end

	// output stage
	logic        px;
	logic [15:0] scaled;
	assign px = font_pixel(rd_q, fcol_q, row_q);
	assign scaled = {8'd0, fade_q} * ({8'd0, bright_q} + 16'd1);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[head_q] <= key_map.glyph;
		end
		rd_q <= ring[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			effect_q    <= EFFECT_MARQUEE;
			speed_q     <= 8'd128;
			bright_q    <= 8'd255;
			head_q      <= '0;
			count_q     <= '0;
			npt_q       <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_EFFECT:     effect_q <= cfg_data[0:0];
					CFG_SPEED:      speed_q  <= cfg_data;
					CFG_BRIGHTNESS: bright_q <= cfg_data;
					default: ;
				endcase
			end
			// in ST_OUT the reload below decides the valid flag
			if (m_axis_tvalid && m_axis_tready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ring_we) begin
						npt_q  <= in_time[15:0];
						head_q <= (head_q == HW'(RING_DEPTH - 1)) ? '0 : HW'(head_q + 1'b1);
						if (count_q != CW'(RING_DEPTH)) begin
							count_q <= count_q + 1'b1;
						end
					end
					if (accept && s_axis_tuser == MODE_QUERY) begin
						col_q  <= in_col;
						row_q  <= in_row;
						rem_q  <= 10'd0;
						mod_q  <= '0;
						q8_q   <= 8'd0;
						cnt_q  <= 5'd0;
						span_q <= SPAN_W'({count_q, 2'b00}) + SPAN_W'(GRID_COLUMNS);
						if (effect_q == EFFECT_MARQUEE) begin
							dvd_q <= in_time;
							dvs_q <= {1'b0, period};
						end else begin
							dvd_q <= {14'd0, ramp_x255};
							dvs_q <= FADE_SPAN_MS;
						end
						if (elapsed < HOLD_MS) begin
							fade_sel_q <= FS_HOLD;
						end else if (elapsed < FADE_END_MS) begin
							fade_sel_q <= FS_FADE;
						end else begin
							fade_sel_q <= FS_OFF;
						end
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? 10'(part - {1'b0, dvs_q}) : part[9:0];
					dvd_q <= {dvd_q[30:0], 1'b0};
					q8_q  <= {q8_q[6:0], qbit};
					mod_q <= (mod2 >= {1'b0, span_q}) ? SPAN_W'(mod2 - {1'b0, span_q})
						: mod2[SPAN_W-1:0];
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					fade_q   <= fade;
					letter_q <= letter;
					if (effect_q == EFFECT_MARQUEE) begin
						fcol_q <= tpos[1:0];
						ok_q   <= row_ok && in_text && (tpos[1:0] != 2'd3);
					end else begin
						fcol_q <= bcol[2:1];
						ok_q   <= row_ok && (fade != 8'd0) && (col_q >= 4'd5) && (col_q <= 4'd10);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_lit_q   <= ok_q && px;
						if (ok_q && px) begin
							if (effect_q == EFFECT_MARQUEE) begin
								out_hue_q <= 8'(letter_q) * HUE_LETTER;
								out_val_q <= bright_q;
							end else begin
								out_hue_q <= {2'b00, rd_q} * HUE_GLYPH;
								out_val_q <= scaled[15:8];
							end
						end else begin
							out_hue_q <= 8'd0;
							out_val_q <= 8'd0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_val_q, out_hue_q, out_lit_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RING_DEPTH))
		else $error("glyph count beyond ring depth");

	a_unlit_black: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[16:1] == 16'd0))
		else $error("unlit pixel carries hue or value");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
		else $error("new item taken while a query is in progress");

endmodule
